[rtl/sdbr_pkg.sv]
// Shared constants and types for the SLIP deframer with its ring of packet buffers.
// Has no dependencies. The top level pulls it in with a wildcard import.
`timescale 1ns / 1ps

package sdbr_pkg;

	localparam int NUM_BUFFERS  = 4;
	localparam int BUFFER_BYTES = 4096;
	localparam int SLOT_W       = $clog2(NUM_BUFFERS);
	localparam int OFF_W        = $clog2(BUFFER_BYTES);
	localparam int LEN_W        = OFF_W + 1;
	localparam int ADDR_W       = SLOT_W + OFF_W;
	localparam int STORE_DEPTH  = NUM_BUFFERS * BUFFER_BYTES;

	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;

	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
	localparam logic [7:0] FLAG_PACKED  = 8'h01;

	typedef enum logic [2:0] {
		PS_WAIT,
		PS_FLAGS,
		PS_DATA,
		PS_UNESC,
		PS_ERROR
	} parse_state_t;

	typedef enum logic [1:0] {
		ACT_RX      = 2'd0,
		ACT_READ    = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_STATUS  = 2'd3
	} action_t;

	// Status of one beat, waiting for the payload store read to return
	typedef struct packed {
		logic              error;
		logic              packet_done;
		logic              buffer_ready;
		logic [LEN_W-1:0]  ready_length;
		logic [7:0]        ready_flags;
		logic              read_hit;
		logic [SLOT_W-1:0] write_slot;
		logic [SLOT_W-1:0] read_slot;
	} status_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == SLOT_W'(NUM_BUFFERS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

[rtl/slip_deframer_buffer_ring_core.sv]
// SLIP deframer writing payload into a ring of packet buffers held in one byte memory.
// Depends on sdbr_pkg for constants, the parser state type and the status struct.
`timescale 1ns / 1ps

// Usage:
//   Input stream s_*: s_tuser carries the action (0 serial byte, 1 read payload byte
//   of the ready buffer, 2 release the ready buffer, 3 status only). s_tdata carries
//   the serial byte and the read offset. Every accepted beat yields one status beat
//   on m_*, in order.
//   Throughput: one beat per cycle while s_tready is high. Parser state, buffer
//   lengths, flags and slot indexes update in the cycle a beat is accepted; the
//   payload memory takes one write or one read per beat on its single port.
//   Pipeline: two register stages (the registered memory read and the output
//   register); each status beat passes through the memory stage and then the output
//   register before it leaves on m_*.
//   Reset: arst_n clears the parser to wait-for-start, all lengths and flags to zero,
//   and both slots to zero. The payload memory is not cleared and needs no sweep:
//   bytes at or past a buffer's length are never returned.
//   Stall: while m_tready is low, a full output register holds and the memory
//   stage fills and holds behind it. s_tready drops only when both are full, so a
//   third beat waits at the input. The writer may overrun the reader: closing a
//   packet onto the read slot clears that buffer.
module slip_deframer_buffer_ring_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] rx_byte, [19:8] read_offset, [23:20] zero
	input  logic [sdbr_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] action
	input  logic [sdbr_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] error, [1] packet_done, [2] buffer_ready, [15:3] ready_length,
	// [23:16] ready_flags, [31:24] read_data, [33:32] write_slot,
	// [35:34] read_slot, [39:36] zero
	output logic [sdbr_pkg::OUT_DATA_W-1:0] m_tdata
);
	import sdbr_pkg::*;

	parse_state_t      state_q, state_d;
	logic [LEN_W-1:0]  len_q [NUM_BUFFERS];
	logic [LEN_W-1:0]  len_d [NUM_BUFFERS];
	logic [7:0]        flg_q [NUM_BUFFERS];
	logic [7:0]        flg_d [NUM_BUFFERS];
	logic [SLOT_W-1:0] wr_q, wr_d, wr_next;
	logic [SLOT_W-1:0] rd_q, rd_d;
	logic              nonempty_q, nonempty_d;

	logic [7:0]        store_mem [STORE_DEPTH];
	logic [7:0]        rdata_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata;

	logic              accept;
	action_t           action;
	logic [7:0]        rx_byte;
	logic [OFF_W-1:0]  read_offset;
	logic              store_req, adv_w, done, ready_now;
	logic [7:0]        store_byte;

	status_t           status_d, st_s1;
	logic              valid_s1, valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;
	logic              adv_s1;

	assign action      = action_t'(s_tuser[1:0]);
	assign rx_byte     = s_tdata[7:0];
	assign read_offset = s_tdata[8 +: OFF_W];

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign ready_now = (wr_q != rd_q);
	assign wr_next  = next_slot(wr_q);

	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		flg_d      = flg_q;
		wr_d       = wr_q;
		rd_d       = rd_q;
		nonempty_d = nonempty_q;
		store_req  = 1'b0;
		store_byte = rx_byte;
		adv_w      = 1'b0;
		done       = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = {wr_q, len_q[wr_q][OFF_W-1:0]};
		mem_raddr  = {rd_q, read_offset};
		mem_wdata  = rx_byte;

		if (accept) begin
			case (action)
				ACT_RX: begin
					case (state_q)
						PS_WAIT: begin
							if (rx_byte == SLIP_END) begin
								state_d    = PS_FLAGS;
								nonempty_d = 1'b0;
							end
						end
						PS_FLAGS, PS_DATA: begin
							if (rx_byte == SLIP_ESC) begin
								state_d = PS_UNESC;
							end else if (rx_byte == SLIP_END) begin
								adv_w = 1'b1;
								if (!nonempty_q) begin
									state_d = PS_ERROR;
								end else begin
									state_d = PS_WAIT;
									done    = 1'b1;
								end
							end else if (state_q == PS_FLAGS) begin
								flg_d[wr_q] = rx_byte;
								state_d     = PS_DATA;
							end else begin
								store_req = 1'b1;
							end
						end
						PS_UNESC: begin
							if (rx_byte == SLIP_ESC_END) begin
								store_req  = 1'b1;
								store_byte = SLIP_END;
								state_d    = PS_DATA;
							end else if (rx_byte == SLIP_ESC_ESC) begin
								store_req  = 1'b1;
								store_byte = SLIP_ESC;
								state_d    = PS_DATA;
							end else begin
								state_d = PS_ERROR;
							end
						end
						default: begin
						end
					endcase
				end
				ACT_READ: begin
					mem_re = 1'b1;
				end
				ACT_RELEASE: begin
					if (ready_now) begin
						len_d[rd_q] = '0;
						rd_d        = next_slot(rd_q);
					end
				end
				default: begin
				end
			endcase
		end

		// drop payload past the buffer size
		if (store_req && (len_q[wr_q] < LEN_W'(BUFFER_BYTES))) begin
			mem_we      = 1'b1;
			mem_wdata   = store_byte;
			len_d[wr_q] = len_q[wr_q] + 1'b1;
			nonempty_d  = 1'b1;
		end

		if (adv_w) begin
			wr_d           = wr_next;
			len_d[wr_next] = '0;
			flg_d[wr_next] = '0;
		end

		status_d.error        = (state_d == PS_ERROR);
		status_d.packet_done  = done;
		status_d.buffer_ready = (wr_d != rd_d);
		status_d.ready_length = len_d[rd_d];
		status_d.ready_flags  = flg_d[rd_d];
		status_d.read_hit     = (action == ACT_READ) && ready_now &&
			({1'b0, read_offset} < len_q[rd_q]);
		status_d.write_slot   = wr_d;
		status_d.read_slot    = rd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PS_WAIT;
			wr_q       <= '0;
			rd_q       <= '0;
			nonempty_q <= 1'b0;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				len_q[i] <= '0;
				flg_q[i] <= '0;
			end
		end else begin
			state_q    <= state_d;
			wr_q       <= wr_d;
			rd_q       <= rd_d;
			nonempty_q <= nonempty_d;
			len_q      <= len_d;
			flg_q      <= flg_d;
		end
	end

	// Payload store: one write or one read per beat, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= store_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1 <= status_d;
		end
		if (adv_s1) begin
			data_s2 <= {4'b0, st_s1.read_slot, st_s1.write_slot,
				(st_s1.read_hit ? rdata_q : 8'h00), st_s1.ready_flags,
				st_s1.ready_length, st_s1.buffer_ready, st_s1.packet_done,
				st_s1.error};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

`ifndef SYNTHESIS
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PS_ERROR |=> state_q == PS_ERROR)
		else $error("parser left the error state");

	a_done_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && st_s1.packet_done |-> !st_s1.error)
		else $error("packet closed while in error");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q[wr_q] <= LEN_W'(BUFFER_BYTES))
		else $error("buffer length past buffer size");

	a_ready_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> st_s1.buffer_ready == (st_s1.write_slot != st_s1.read_slot))
		else $error("buffer_ready disagrees with slots");

	a_write_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept && done |=> wr_q == next_slot($past(wr_q)) && len_q[wr_q] == '0)
		else $error("closed packet did not advance the write slot");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for slip_deframer_buffer_ring_core: directed and random beats,
// a beat-level predictor of the deframer and its buffer ring, and a result checker.
// Depends on sdbr_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;
	import sdbr_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_BEATS = 760;
	localparam int DRAIN_CYCLES = 8;

	// Same layout as m_tdata, lowest field last
	typedef struct packed {
		logic [3:0]        pad;
		logic [SLOT_W-1:0] read_slot;
		logic [SLOT_W-1:0] write_slot;
		logic [7:0]        fetched_byte;
		logic [7:0]        ready_flags;
		logic [LEN_W-1:0]  ready_length;
		logic              buffer_ready;
		logic              packet_done;
		logic              error;
	} deframe_status_t;

	typedef logic [7:0] byte_q_t [$];

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Predictor state
	parse_state_t      parse = PS_WAIT;
	logic [7:0]        pay_mem [STORE_DEPTH];
	logic [LEN_W-1:0]  buf_len [NUM_BUFFERS] = '{default: '0};
	logic [7:0]        buf_flags [NUM_BUFFERS] = '{default: '0};
	logic [SLOT_W-1:0] wr_slot = '0;
	logic [SLOT_W-1:0] rd_slot = '0;
	int                pkt_bytes = 0;

	deframe_status_t status_q [$];
	int              fail_count = 0;
	int              beats_sent = 0;
	int              stall_left = 0;
	int              cycle;
	bit              tx_steady = 1'b0;
	bit              rx_steady = 1'b0;

	slip_deframer_buffer_ring_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
		return SLOT_W'((int'(s) + 1) % NUM_BUFFERS);
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		logic [ADDR_W-1:0] addr;
		if (buf_len[wr_slot] < BUFFER_BYTES) begin
			addr = {wr_slot, buf_len[wr_slot][OFF_W-1:0]};
			pay_mem[addr] = b;
			buf_len[wr_slot]++;
			pkt_bytes++;
		end
	endfunction

	function automatic deframe_status_t predict_beat(input action_t act, input logic [7:0] b,
			input logic [OFF_W-1:0] off);
		deframe_status_t st;
		logic ready;
		st = '0;
		ready = (wr_slot != rd_slot);
		case (act)
			ACT_RX: begin
				case (parse)
					PS_WAIT: begin
						if (b == SLIP_END) begin
							parse = PS_FLAGS;
							pkt_bytes = 0;
						end
					end
					PS_FLAGS, PS_DATA: begin
						if (b == SLIP_ESC) begin
							parse = PS_UNESC;
						end else if (b == SLIP_END) begin
							// close: move to the next buffer and wipe it
							wr_slot = ring_next(wr_slot);
							buf_len[wr_slot] = '0;
							buf_flags[wr_slot] = '0;
							if (pkt_bytes == 0) begin
								parse = PS_ERROR;
							end else begin
								parse = PS_WAIT;
								st.packet_done = 1'b1;
							end
						end else if (parse == PS_FLAGS) begin
							buf_flags[wr_slot] = b;
							parse = PS_DATA;
						end else begin
							store_byte(b);
						end
					end
					PS_UNESC: begin
						if (b == SLIP_ESC_END) begin
							store_byte(SLIP_END);
							parse = PS_DATA;
						end else if (b == SLIP_ESC_ESC) begin
							store_byte(SLIP_ESC);
							parse = PS_DATA;
						end else begin
							parse = PS_ERROR;
						end
					end
					default: ;
				endcase
			end
			ACT_READ: begin
				if (ready && off < buf_len[rd_slot])
					st.fetched_byte = pay_mem[{rd_slot, off}];
			end
			ACT_RELEASE: begin
				if (ready) begin
					buf_len[rd_slot] = '0;
					rd_slot = ring_next(rd_slot);
				end
			end
			default: ;
		endcase
		st.error = (parse == PS_ERROR);
		st.buffer_ready = (wr_slot != rd_slot);
		st.ready_length = buf_len[rd_slot];
		st.ready_flags = buf_flags[rd_slot];
		st.write_slot = wr_slot;
		st.read_slot = rd_slot;
		return st;
	endfunction

	// Mostly back to back, some short gaps, a few long ones
	function automatic int idle_cycles(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [7:0] random_byte();
		if ($urandom_range(0, 99) < 16) begin
			case ($urandom_range(0, 3))
				0: return SLIP_END;
				1: return SLIP_ESC;
				2: return SLIP_ESC_END;
				default: return SLIP_ESC_ESC;
			endcase
		end
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] random_flags();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return r[0] ? SLIP_END : SLIP_ESC;
		if (r < 20)
			return r[0] ? FLAG_PACKED : 8'h00;
		return 8'($urandom);
	endfunction

	task automatic send_beat(input action_t act, input logic [7:0] b,
			input logic [OFF_W-1:0] off);
		int gap;
		status_q.push_back(predict_beat(act, b, off));
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - OFF_W - 8){1'b0}}, off, b};
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
		gap = idle_cycles(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_rx(input logic [7:0] b);
		send_beat(ACT_RX, b, OFF_W'($urandom));
	endtask

	task automatic send_read(input logic [OFF_W-1:0] off);
		send_beat(ACT_READ, 8'($urandom), off);
	endtask

	task automatic send_escaped(input logic [7:0] b);
		if (b == SLIP_END) begin
			send_rx(SLIP_ESC);
			send_rx(SLIP_ESC_END);
		end else if (b == SLIP_ESC) begin
			send_rx(SLIP_ESC);
			send_rx(SLIP_ESC_ESC);
		end else begin
			send_rx(b);
		end
	endtask

	// An escaped flags byte turns into payload, so a packet here is never empty
	task automatic send_frame(input logic [7:0] flags, input byte_q_t payload);
		send_rx(SLIP_END);
		send_escaped(flags);
		foreach (payload[i])
			send_escaped(payload[i]);
		send_rx(SLIP_END);
	endtask

	task automatic drain_results();
		if (status_q.size() != 0) begin
			s_tvalid <= 1'b0;
			while (status_q.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic test_reader_when_empty();
		send_beat(ACT_RELEASE, 8'($urandom), OFF_W'($urandom));
		send_beat(ACT_STATUS, 8'($urandom), OFF_W'($urandom));
		send_read('0);
		// bytes before any opening delimiter are dropped
		send_rx(8'h55);
		send_rx(SLIP_ESC);
		send_rx(SLIP_ESC_END);
		send_rx(8'h00);
		send_rx(8'hFF);
	endtask

	task automatic test_escape_packet();
		send_frame(FLAG_PACKED, '{8'h00, 8'hFF, SLIP_END, SLIP_ESC, SLIP_ESC_END,
			SLIP_ESC_ESC});
		for (int i = 0; i < 7; i++)
			send_read(OFF_W'(i));
		send_beat(ACT_RELEASE, 8'($urandom), OFF_W'($urandom));
	endtask

	task automatic test_flag_escape();
		send_frame(SLIP_END, '{8'h3C});
		send_read('0);
		send_read(OFF_W'(1));
		send_beat(ACT_RELEASE, 8'($urandom), OFF_W'($urandom));
	endtask

	task automatic test_overrun();
		byte_q_t payload;
		drain_results();
		// close one packet per buffer so the writer lands on the read slot
		for (int p = 0; p < NUM_BUFFERS; p++) begin
			payload = {};
			repeat ($urandom_range(1, 5))
				payload.push_back(random_byte());
			send_frame((p == 0) ? 8'h00 : random_flags(), payload);
		end
		send_read('0);
		send_beat(ACT_RELEASE, 8'($urandom), OFF_W'($urandom));
		send_beat(ACT_STATUS, 8'($urandom), OFF_W'($urandom));
		send_frame(FLAG_PACKED, '{8'h5A, 8'hA5});
		send_read('0);
		send_read(OFF_W'(1));
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int r;
		logic [7:0] b;
		logic [OFF_W-1:0] off;
		byte_q_t payload;
		stop_at = beats_sent + RANDOM_BEATS;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 49) == 0)
				tx_steady = !tx_steady;
			if ($urandom_range(0, 49) == 0)
				rx_steady = !rx_steady;
			r = $urandom_range(0, 99);
			if (r < 2) begin
				drain_results();
			end else if (r < 45) begin
				payload = {};
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) :
						$urandom_range(1, 12))
					payload.push_back(random_byte());
				send_frame(random_flags(), payload);
			end else if (r < 48) begin
				// line noise between packets, never an opening delimiter
				repeat ($urandom_range(1, 4)) begin
					do b = 8'($urandom); while (b == SLIP_END);
					send_rx(b);
				end
			end else if (r < 78) begin
				r = $urandom_range(0, 99);
				if (buf_len[rd_slot] != 0 && r < 60)
					off = OFF_W'($urandom % buf_len[rd_slot]);
				else if (r < 80)
					off = OFF_W'(buf_len[rd_slot] + $urandom_range(0, 3));
				else
					off = OFF_W'($urandom);
				send_read(off);
			end else if (r < 93) begin
				send_beat(ACT_RELEASE, 8'($urandom), OFF_W'($urandom));
			end else begin
				send_beat(ACT_STATUS, 8'($urandom), OFF_W'($urandom));
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// The error is sticky until reset, so only one kind can be hit per run
	task automatic test_error_tail();
		logic [7:0] bad;
		int r;
		drain_results();
		case ($urandom_range(0, 2))
			0: begin
				send_rx(SLIP_END);
				send_rx(SLIP_END);
			end
			1: begin
				send_rx(SLIP_END);
				send_rx(FLAG_PACKED);
				send_rx(SLIP_END);
			end
			default: begin
				do bad = 8'($urandom); while (bad == SLIP_ESC_END || bad == SLIP_ESC_ESC);
				send_rx(SLIP_END);
				send_rx(8'h02);
				send_rx(8'h11);
				send_rx(SLIP_ESC);
				send_rx(bad);
			end
		endcase
		// the parser stays dead; the reader side keeps working
		repeat (40) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				send_frame(random_flags(), '{random_byte(), random_byte()});
			else if (r < 70)
				send_read(OFF_W'($urandom_range(0, 7)));
			else if (r < 85)
				send_beat(ACT_RELEASE, 8'($urandom), OFF_W'($urandom));
			else
				send_beat(ACT_STATUS, 8'($urandom), OFF_W'($urandom));
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			stall_left <= idle_cycles(rx_steady);
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		deframe_status_t got;
		deframe_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = deframe_status_t'(m_tdata);
			if (status_q.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none, got %h", $time,
					m_tdata);
				fail_count++;
			end else begin
				want = status_q.pop_front();
				check_field("error", want.error, got.error);
				check_field("packet_done", want.packet_done, got.packet_done);
				check_field("buffer_ready", want.buffer_ready, got.buffer_ready);
				check_field("ready_length", want.ready_length, got.ready_length);
				check_field("ready_flags", want.ready_flags, got.ready_flags);
				check_field("fetched_byte", want.fetched_byte, got.fetched_byte);
				check_field("write_slot", want.write_slot, got.write_slot);
				check_field("read_slot", want.read_slot, got.read_slot);
				check_field("pad", want.pad, got.pad);
			end
		end
	end

	initial begin
		for (cycle = 0; cycle < CYCLE_LIMIT; cycle++)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reader_when_empty();
		test_escape_packet();
		test_flag_escape();
		test_overrun();
		test_random_traffic();
		test_error_tail();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (status_q.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, status_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[slip_deframer_buffer_ring_core.f]
rtl/sdbr_pkg.sv
rtl/slip_deframer_buffer_ring_core.sv
tb/testbench.sv
